// ===== hdl/pcwa_pkg.sv =====
// ----------------------------------------------------------------------------
// pcwa_pkg
// Shared widths, control-word types, microprogram and clamp helper for the
// PI climb controller with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
package pcwa_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int REG_W      = DATA_WIDTH - 1;
  localparam int IDX_W      = 3;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SHR_W      = PROD_W - FRAC_BITS;
  localparam int WIDE_W     = SHR_W + 1;
  localparam int STEP_W     = 3;

  typedef logic [STEP_W-1:0] step_t;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_CLIMB_LIMIT = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_PITCH_GAIN  = 3'd4,
    REG_ANGLE_LIMIT = 3'd5,
    REG_STEP_TIME   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MA_PROP, MA_INTEG, MA_STEP, MA_PITCH
  } mul_a_sel_t;

  typedef enum logic [1:0] {
    MB_ERR, MB_ACC, MB_CLIMB
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD_ERR, OP_LOAD_RAW, OP_ADD_RAW, OP_CLIMB, OP_ACC_UPD, OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    CND_NEXT,   // advance
    CND_IN,     // hold until an input request arrives
    CND_OUT     // hold until the output register is free, then jump
  } cond_t;

  typedef struct packed {
    logic       mul_en;
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    dp_op_t     op;
    cond_t      cond;
    step_t      target;
  } ctl_word_t;

  localparam step_t STEP_START = step_t'(0);

  // Microprogram: one control word per step.
  function automatic ctl_word_t ucode(input step_t s);
    ctl_word_t w;
    w = '{mul_en: 1'b0, mul_a: MA_PROP, mul_b: MB_ERR, op: OP_NONE,
          cond: CND_NEXT, target: STEP_START};
    case (s)
      3'd0: begin w.op = OP_LOAD_ERR; w.cond = CND_IN; end
      3'd1: begin w.mul_en = 1'b1; w.mul_a = MA_PROP; w.mul_b = MB_ERR; end
      3'd2: begin
        w.mul_en = 1'b1; w.mul_a = MA_INTEG; w.mul_b = MB_ACC; w.op = OP_LOAD_RAW;
      end
      3'd3: begin
        w.mul_en = 1'b1; w.mul_a = MA_STEP; w.mul_b = MB_ERR; w.op = OP_ADD_RAW;
      end
      3'd4: begin w.op = OP_CLIMB; end
      3'd5: begin
        w.mul_en = 1'b1; w.mul_a = MA_PITCH; w.mul_b = MB_CLIMB; w.op = OP_ACC_UPD;
      end
      3'd6: begin w.op = OP_EMIT; w.cond = CND_OUT; w.target = STEP_START; end
      default: begin w.cond = CND_OUT; w.target = STEP_START; end
    endcase
    return w;
  endfunction

  // Symmetric clamp of a wide signed value to +-lim.
  function automatic logic signed [DATA_WIDTH-1:0] clamp_sym(
    input logic signed [WIDE_W-1:0] v,
    input logic [REG_W-1:0]         lim
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] r;
    hi = signed'(WIDE_W'(lim));
    lo = -hi;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r[DATA_WIDTH-1:0];
  endfunction

endpackage

// ===== hdl/pcwa_if.sv =====
// ----------------------------------------------------------------------------
// pcwa channel interfaces
// Valid/ready channels for input, result and register-write requests.
// ----------------------------------------------------------------------------
interface pcwa_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [pcwa_pkg::DATA_WIDTH-1:0]     altitude_error;
  modport source (output valid, output altitude_error, input ready);
  modport sink   (input valid, input altitude_error, output ready);
endinterface

interface pcwa_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [pcwa_pkg::DATA_WIDTH-1:0]     climb_rate;
  logic signed [pcwa_pkg::DATA_WIDTH-1:0]     attack_angle;
  modport source (output valid, output climb_rate, output attack_angle, input ready);
  modport sink   (input valid, input climb_rate, input attack_angle, output ready);
endinterface

interface pcwa_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [pcwa_pkg::IDX_W-1:0]                 index;
  logic [pcwa_pkg::DATA_WIDTH-1:0]            data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pi_climb_with_antiwindup_top.sv =====
// ----------------------------------------------------------------------------
// pi_climb_with_antiwindup_top
// A request runs through the 7-step microprogram, which sends all four products
// through a single shared 33x32 multiplier; a new request is taken only once
// the previous one has been emitted, and the emit step waits while the previous
// result still sits unaccepted in the output register.
// Reset (rst_n low, synchronous) zeroes the configuration registers and the
// accumulator, clears output valid and returns the sequencer to its wait step.
// ----------------------------------------------------------------------------
module pi_climb_with_antiwindup_top (
  input  logic            clk,
  input  logic            rst_n,
  pcwa_in_if.sink         in_ch,
  pcwa_out_if.source      out_ch,
  pcwa_cfg_if.sink        cfg_ch
);

  localparam int DW = pcwa_pkg::DATA_WIDTH;
  localparam int FB = pcwa_pkg::FRAC_BITS;
  localparam int RW = pcwa_pkg::REG_W;
  localparam int PW = pcwa_pkg::PROD_W;
  localparam int SW = pcwa_pkg::SHR_W;
  localparam int WW = pcwa_pkg::WIDE_W;

  // --------------------------------------------------------------------------
  // Configuration registers: writes always taken; top data bit dropped and
  // unknown indexes ignored.
  // --------------------------------------------------------------------------
  logic [RW-1:0] prop_gain_r, integ_gain_r, climb_limit_r, integ_limit_r;
  logic [RW-1:0] pitch_gain_r, angle_limit_r, step_time_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      climb_limit_r <= '0;
      integ_limit_r <= '0;
      pitch_gain_r  <= '0;
      angle_limit_r <= '0;
      step_time_r   <= '0;
    end else if (cfg_ch.valid) begin
      case (pcwa_pkg::reg_idx_t'(cfg_ch.index))
        pcwa_pkg::REG_PROP_GAIN:   prop_gain_r   <= cfg_ch.data[RW-1:0];
        pcwa_pkg::REG_INTEG_GAIN:  integ_gain_r  <= cfg_ch.data[RW-1:0];
        pcwa_pkg::REG_CLIMB_LIMIT: climb_limit_r <= cfg_ch.data[RW-1:0];
        pcwa_pkg::REG_INTEG_LIMIT: integ_limit_r <= cfg_ch.data[RW-1:0];
        pcwa_pkg::REG_PITCH_GAIN:  pitch_gain_r  <= cfg_ch.data[RW-1:0];
        pcwa_pkg::REG_ANGLE_LIMIT: angle_limit_r <= cfg_ch.data[RW-1:0];
        pcwa_pkg::REG_STEP_TIME:   step_time_r   <= cfg_ch.data[RW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: step counter addresses the microprogram ROM.
  // --------------------------------------------------------------------------
  pcwa_pkg::step_t     step_r, step_nxt;
  pcwa_pkg::ctl_word_t ctl;
  logic                out_valid_r;
  logic                out_free;
  logic                in_fire;
  logic                emit_fire;

  assign ctl       = pcwa_pkg::ucode(step_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (ctl.cond == pcwa_pkg::CND_IN);
  assign in_fire   = in_ch.ready && in_ch.valid;
  assign emit_fire = (ctl.op == pcwa_pkg::OP_EMIT) && out_free;

  always_comb begin
    step_nxt = step_r;
    case (ctl.cond)
      pcwa_pkg::CND_NEXT: step_nxt = step_r + pcwa_pkg::step_t'(1);
      pcwa_pkg::CND_IN:   if (in_ch.valid) step_nxt = step_r + pcwa_pkg::step_t'(1);
      pcwa_pkg::CND_OUT:  if (out_free) step_nxt = ctl.target;
      default:            step_nxt = pcwa_pkg::STEP_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= pcwa_pkg::STEP_START;
    else        step_r <= step_nxt;
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: unsigned gain (zero-extended) times signed operand,
  // registered before use.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]   err_r;
  logic signed [DW-1:0]   acc_r;
  logic signed [DW-1:0]   climb_r;
  logic signed [DW:0]     mul_a;
  logic signed [DW-1:0]   mul_b;
  logic signed [PW:0]     mul_full;
  logic signed [PW-1:0]   prod_r;
  logic signed [SW-1:0]   prod_shr;

  always_comb begin
    case (ctl.mul_a)
      pcwa_pkg::MA_PROP:  mul_a = signed'({2'b00, prop_gain_r});
      pcwa_pkg::MA_INTEG: mul_a = signed'({2'b00, integ_gain_r});
      pcwa_pkg::MA_STEP:  mul_a = signed'({2'b00, step_time_r});
      pcwa_pkg::MA_PITCH: mul_a = signed'({2'b00, pitch_gain_r});
      default:            mul_a = '0;
    endcase
    case (ctl.mul_b)
      pcwa_pkg::MB_ERR:   mul_b = err_r;
      pcwa_pkg::MB_ACC:   mul_b = acc_r;
      pcwa_pkg::MB_CLIMB: mul_b = climb_r;
      default:            mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * mul_b;
  // truncate toward minus infinity: drop the fraction bits
  assign prod_shr = prod_r[PW-1:FB];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) prod_r <= mul_full[PW-1:0];
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic signed [WW-1:0] raw_r;
  logic signed [WW-1:0] sum_r;
  logic                 freeze_r;
  logic signed [WW-1:0] raw_lim;
  logic                 saturated;
  logic                 err_aligned;
  logic signed [DW-1:0] out_climb_r, out_angle_r;

  assign raw_lim     = signed'(WW'(climb_limit_r));
  assign saturated   = (raw_r <= -raw_lim) || (raw_r >= raw_lim);
  // both non-negative or both negative
  assign err_aligned = (raw_r[WW-1] == err_r[DW-1]);

  always_ff @(posedge clk) begin
    case (ctl.op)
      pcwa_pkg::OP_LOAD_ERR: if (in_fire) err_r <= in_ch.altitude_error;
      pcwa_pkg::OP_LOAD_RAW: raw_r <= WW'(prod_shr);
      pcwa_pkg::OP_ADD_RAW:  raw_r <= raw_r + WW'(prod_shr);
      pcwa_pkg::OP_CLIMB: begin
        climb_r  <= pcwa_pkg::clamp_sym(raw_r, climb_limit_r);
        freeze_r <= saturated && err_aligned;
        // prod_r holds error*step_time here
        sum_r    <= WW'(acc_r) + WW'(prod_shr);
      end
      pcwa_pkg::OP_EMIT: begin
        if (emit_fire) begin
          out_climb_r <= climb_r;
          out_angle_r <= pcwa_pkg::clamp_sym(WW'(prod_shr), angle_limit_r);
        end
      end
      default: ;
    endcase
  end

  // Accumulator: control state, cleared by reset; hold when anti-windup fires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.op == pcwa_pkg::OP_ACC_UPD && !freeze_r) begin
      acc_r <= pcwa_pkg::clamp_sym(sum_r, integ_limit_r);
    end
  end

  // Output register: load on emit, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.climb_rate   = out_climb_r;
  assign out_ch.attack_angle = out_angle_r;

endmodule

// ===== tb/pi_climb_with_antiwindup_top_tb.sv =====
// ----------------------------------------------------------------------------
// pi_climb_with_antiwindup_top_tb
// Self-checking regression for the PI climb controller. A directed table
// walks through the zero reset state, the field extremes, conditional
// integration and out-of-range register writes. Randomized phases follow
// under varied gains and limits. Every result is compared field by field
// against an in-bench controller model or a result typed into the table.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pi_climb_with_antiwindup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = pcwa_pkg::DATA_WIDTH;
  localparam int IW = pcwa_pkg::IDX_W;
  localparam int RW = pcwa_pkg::REG_W;
  localparam int FB = pcwa_pkg::FRAC_BITS;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_CYCLES      = 20;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int DIRECTED_COUNT  = 43;
  localparam int REG_COUNT       = int'(pcwa_pkg::REG_STEP_TIME) + 1;
  localparam int ERR_SPAN        = 32'h0004_0000;

  localparam logic [IW-1:0] BAD_REG_IDX = 3'd7;
  localparam logic [DW-1:0] Q_ONE       = 32'h0001_0000;
  localparam logic [DW-1:0] Q_MAX       = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] Q_MIN       = 32'h8000_0000;
  localparam logic [DW-1:0] ALL_ONES    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DW-1:0] climb_rate;
    logic [DW-1:0] attack_angle;
  } result_t;

  // A table row is either one request on the error channel or one register write.
  typedef enum logic {ROW_ERR, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [IW-1:0] idx;
    logic [DW-1:0] value;
    logic          known;   // expected result typed in below
    logic [DW-1:0] climb;
    logic [DW-1:0] angle;
  } row_t;

  typedef enum logic [1:0] {
    SET_MODERATE, SET_MAX, SET_ZERO_LIMITS, SET_WIDE
  } setting_mode_t;

  localparam row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    // all registers zero after reset: both outputs pinned at zero
    '{ROW_ERR, '0, Q_MAX, 1'b1, 32'h0, 32'h0},
    '{ROW_ERR, '0, Q_MIN, 1'b1, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'h0, 1'b1, 32'h0, 32'h0},
    // proportional path only, unity gains, climb clamp 5.0, angle clamp 2.0
    '{ROW_REG, pcwa_pkg::REG_PROP_GAIN,   Q_ONE,         1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_CLIMB_LIMIT, 32'h0005_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_PITCH_GAIN,  Q_ONE,         1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_ANGLE_LIMIT, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, Q_MAX, 1'b1, 32'h0005_0000, 32'h0002_0000},
    '{ROW_ERR, '0, Q_MIN, 1'b1, 32'hFFFB_0000, 32'hFFFE_0000},
    '{ROW_ERR, '0, Q_ONE, 1'b1, Q_ONE, Q_ONE},
    // smallest negative error: truncation must go toward minus infinity
    '{ROW_ERR, '0, ALL_ONES, 1'b0, 32'h0, 32'h0},
    // integrator on, accumulator clamp 3.0, loose climb clamp
    '{ROW_REG, pcwa_pkg::REG_INTEG_GAIN,  Q_ONE,         1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_STEP_TIME,   Q_ONE,         1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_INTEG_LIMIT, 32'h0003_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_CLIMB_LIMIT, 32'h000A_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_PITCH_GAIN,  32'h0000_8000, 1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_ANGLE_LIMIT, Q_MAX,         1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    // tight climb clamp: hold, saturated against the error, hold again
    '{ROW_REG, pcwa_pkg::REG_CLIMB_LIMIT, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'h0004_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'hFFF8_0000, 1'b0, 32'h0, 32'h0},
    // zero climb clamp always counts as saturated
    '{ROW_REG, pcwa_pkg::REG_CLIMB_LIMIT, 32'h0, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, Q_ONE,         1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'h0,         1'b0, 32'h0, 32'h0},
    // write to a missing register is dropped; bit 31 of the data is dropped
    '{ROW_REG, BAD_REG_IDX,               32'h1234_5678, 1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_CLIMB_LIMIT, ALL_ONES,      1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'h0004_0000, 1'b0, 32'h0, 32'h0},
    // every register at its top value
    '{ROW_REG, pcwa_pkg::REG_PROP_GAIN,   ALL_ONES, 1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_INTEG_GAIN,  Q_MAX,    1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_CLIMB_LIMIT, Q_MAX,    1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_INTEG_LIMIT, ALL_ONES, 1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_PITCH_GAIN,  Q_MAX,    1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_ANGLE_LIMIT, ALL_ONES, 1'b0, 32'h0, 32'h0},
    '{ROW_REG, pcwa_pkg::REG_STEP_TIME,   Q_MAX,    1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, Q_MAX, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, Q_MIN, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, Q_MIN, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, Q_MAX, 1'b0, 32'h0, 32'h0},
    '{ROW_ERR, '0, 32'h0, 1'b0, 32'h0, 32'h0}
  };

  setting_mode_t phase_plan [NUM_PHASES] = '{
    SET_MODERATE, SET_MODERATE, SET_MAX, SET_WIDE, SET_ZERO_LIMITS, SET_MODERATE, SET_WIDE
  };

  logic clk;
  logic rst_n;

  pcwa_in_if  in_ch ();
  pcwa_out_if out_ch ();
  pcwa_cfg_if cfg_ch ();

  pi_climb_with_antiwindup_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Controller model state: register file and integral accumulator.
  longint  gain_regs [REG_COUNT];
  longint  integ_acc;
  result_t expected_results [$];

  bit steady;         // no idling on either side while set
  int stall_left;
  int fail_count;
  int requests_sent;
  int results_checked;
  int reg_writes;
  int held_count;
  int clipped_count;
  int cycle_count;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Controller model
  // --------------------------------------------------------------------------
  function automatic longint limit_to(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Registers hold 31 bits; anything at a missing index goes nowhere.
  function automatic void store_register(input logic [IW-1:0] idx,
                                         input logic [DW-1:0] val);
    if (idx <= pcwa_pkg::REG_STEP_TIME) gain_regs[idx] = longint'(val[RW-1:0]);
  endfunction

  // One control tick. Products fit in 63 bits, so longint carries them exactly,
  // and an arithmetic shift gives the floor that the hardware truncation gives.
  function automatic result_t advance_controller(input logic signed [DW-1:0] err_in);
    longint  err;
    longint  raw;
    longint  climb;
    longint  angle;
    longint  lim;
    longint  step_inc;
    bit      saturated;
    bit      err_aligned;
    result_t res;
    err = err_in;
    lim = gain_regs[pcwa_pkg::REG_CLIMB_LIMIT];
    raw = ((gain_regs[pcwa_pkg::REG_PROP_GAIN] * err) >>> FB) +
          ((gain_regs[pcwa_pkg::REG_INTEG_GAIN] * integ_acc) >>> FB);
    climb = limit_to(raw, lim);
    if (raw > lim || raw < -lim) clipped_count++;
    saturated   = (raw <= -lim) || (raw >= lim);
    err_aligned = (raw >= 0) == (err >= 0);
    // conditional integration: freeze while pushing further into the clamp
    if (saturated && err_aligned) begin
      held_count++;
    end else begin
      step_inc  = (err * gain_regs[pcwa_pkg::REG_STEP_TIME]) >>> FB;
      integ_acc = limit_to(integ_acc + step_inc, gain_regs[pcwa_pkg::REG_INTEG_LIMIT]);
    end
    angle = limit_to((gain_regs[pcwa_pkg::REG_PITCH_GAIN] * climb) >>> FB,
                     gain_regs[pcwa_pkg::REG_ANGLE_LIMIT]);
    res.climb_rate   = climb[DW-1:0];
    res.attack_angle = angle[DW-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Small errors keep the integrator in play; lean biases a run to one sign.
  function automatic logic [DW-1:0] pick_error(input int lean);
    int r;
    int mag;
    r   = $urandom_range(0, 99);
    mag = int'($urandom_range(0, ERR_SPAN));
    if (r < 65) begin
      if (lean == 0) return $urandom_range(0, 1) ? 32'(mag) : 32'(-mag);
      return 32'(mag * lean);
    end
    if (r < 75) begin
      case ($urandom_range(0, 4))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return 32'h0;
        3: return ALL_ONES;
        default: return 32'h1;
      endcase
    end
    return $urandom;
  endfunction

  // Bit 31 of the data is random everywhere: the block must drop it.
  function automatic logic [DW-1:0] setting_value(input setting_mode_t mode,
                                                   input pcwa_pkg::reg_idx_t idx);
    logic top;
    int   span;
    top = $urandom_range(0, 1);
    if (mode == SET_MAX) return {top, {RW{1'b1}}};
    if (mode == SET_WIDE) return $urandom;
    if (mode == SET_ZERO_LIMITS &&
        (idx == pcwa_pkg::REG_CLIMB_LIMIT || idx == pcwa_pkg::REG_INTEG_LIMIT ||
         idx == pcwa_pkg::REG_ANGLE_LIMIT))
      return {top, {RW{1'b0}}};
    if ($urandom_range(0, 7) == 0) return {top, {RW{1'b0}}};
    case (idx)
      pcwa_pkg::REG_PROP_GAIN:   span = 32'h0003_0000;
      pcwa_pkg::REG_INTEG_GAIN:  span = 32'h0000_8000;
      pcwa_pkg::REG_CLIMB_LIMIT: span = 32'h0008_0000;
      pcwa_pkg::REG_INTEG_LIMIT: span = 32'h0010_0000;
      pcwa_pkg::REG_PITCH_GAIN:  span = 32'h0000_8000;
      pcwa_pkg::REG_ANGLE_LIMIT: span = 32'h0002_0000;
      default:                   span = 32'h0000_4000;
    endcase
    return {top, RW'($urandom_range(0, span))};
  endfunction

  // Record a failure; print only the first few.
  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  function automatic void check_field(input string field, input logic [DW-1:0] want,
                                      input logic [DW-1:0] got);
    if (want !== got)
      flag_failure($sformatf("%s on result %0d: expected %h, got %h",
                             field, results_checked, want, got));
  endfunction

  // Present one request; hold it until accepted, then queue its expected result.
  task automatic send_error(input logic [DW-1:0] err, input logic known,
                            input result_t typed_result);
    int      gap;
    result_t want;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.altitude_error <= err;
    do @(posedge clk); while (!in_ch.ready);
    want = advance_controller(err);
    expected_results.push_back(known ? typed_result : want);
    requests_sent++;
  endtask

  // Drop the request line and let every outstanding result come home.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    store_register(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Rewrite the whole register file, plus one write to a missing index.
  task automatic apply_setting(input setting_mode_t mode);
    for (int i = 0; i < REG_COUNT; i++)
      write_register(IW'(i), setting_value(mode, pcwa_pkg::reg_idx_t'(i)));
    write_register(BAD_REG_IDX, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random backpressure, advanced at the falling edge
  // --------------------------------------------------------------------------
  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (steady) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        flag_failure($sformatf("unexpected result: climb_rate %h attack_angle %h",
                               out_ch.climb_rate, out_ch.attack_angle));
      end else begin
        want = expected_results.pop_front();
        check_field("climb_rate", want.climb_rate, out_ch.climb_rate);
        check_field("attack_angle", want.attack_angle, out_ch.attack_angle);
        results_checked++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, expected_results.size());
      $display("pi_climb_with_antiwindup_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int   lean;
    int   directed_requests;
    row_t row;

    // drive every input to a known value from time zero
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.altitude_error = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    steady               = 1'b0;
    stall_left           = 0;
    integ_acc            = 0;
    lean                 = 0;
    for (int i = 0; i < REG_COUNT; i++) gain_regs[i] = 0;

    // hold reset, then release it at a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: register rows only go in once the block is idle.
    for (int n = 0; n < DIRECTED_COUNT; n++) begin
      row = DIRECTED_ROWS[n];
      if (row.kind == ROW_REG) begin
        wait_idle();
        write_register(row.idx, row.value);
      end else begin
        send_error(row.value, row.known, '{climb_rate: row.climb, attack_angle: row.angle});
      end
    end
    directed_requests = requests_sent;

    // Random phases: fresh registers each time, sign-leaning runs of errors,
    // and now and then a stretch where neither side idles.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      apply_setting(phase_plan[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 16 == 0) lean = int'($urandom_range(0, 2)) - 1;
        if (k % 50 == 0) steady = ($urandom_range(0, 4) == 0);
        send_error(pick_error(lean), 1'b0, '0);
      end
    end
    steady = 1'b0;

    // drain, then keep watching so that any stray result still shows
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      flag_failure($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("covered %0d requests (%0d from the directed table), %0d register writes,",
             requests_sent, directed_requests, reg_writes);
    $display("%0d results compared; integrator held on %0d requests, climb clipped on %0d",
             results_checked, held_count, clipped_count);
    if (fail_count == 0) begin
      $display("pi_climb_with_antiwindup_top regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("pi_climb_with_antiwindup_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pcwa_pkg.sv
hdl/pcwa_if.sv
hdl/pi_climb_with_antiwindup_top.sv
tb/pi_climb_with_antiwindup_top_tb.sv
